// ----- rtl/spi_mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_mbe_pkg
// shared types and constants for the spi master byte engine
// ----------------------------------------------------------------------------
package spi_mbe_pkg;

    localparam int FRAME_BITS_DEF = 8;
    localparam int DIV_W          = 3;
    localparam int DIV_MAX        = 7;
    localparam int TICK_W         = 7;
    localparam int KIND_W         = 2;
    localparam int RX_W           = 8;
    localparam int TX_W           = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CPOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CPHA = 2'd2;

    localparam logic [KIND_W-1:0] KIND_EXCHANGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEND     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECEIVE  = 2'd2;

    typedef struct packed {
        logic [DIV_W-1:0] div_exp;
        logic             cpol;
        logic             cpha;
    } cfg_t;

    typedef struct packed {
        logic            sclk;
        logic            mosi;
        logic            busy;
        logic            rx_valid;
        logic [RX_W-1:0] rx_byte;
        logic            cmd_rejected;
    } res_t;

endpackage

// ----- rtl/spi_mbe_shifter.sv -----
// ----------------------------------------------------------------------------
// spi_mbe_shifter
// frame state, sclk edge counting and the tx/rx shift registers
// ----------------------------------------------------------------------------
module spi_mbe_shifter #(
    parameter int FRAME_BITS = spi_mbe_pkg::FRAME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             cmd_valid,
    input  logic [spi_mbe_pkg::KIND_W-1:0]   kind,
    input  logic [spi_mbe_pkg::TX_W-1:0]     tx_byte,
    input  logic                             miso,
    input  spi_mbe_pkg::cfg_t                cfg,
    output spi_mbe_pkg::res_t                res
);

    localparam int EDGE_W  = $clog2(2 * FRAME_BITS);
    localparam int EDGE_XW = EDGE_W + 1;
    localparam int TICK_W  = spi_mbe_pkg::TICK_W;
    localparam logic [EDGE_XW-1:0] LAST_EDGE = EDGE_XW'(2 * FRAME_BITS);

    logic                            active_reg,     active_next;
    logic [EDGE_W-1:0]               edge_count_reg, edge_count_next;
    logic [TICK_W-1:0]               tick_count_reg, tick_count_next;
    logic [FRAME_BITS-1:0]           shift_out_reg,  shift_out_next;
    logic [FRAME_BITS-1:0]           shift_in_reg,   shift_in_next;
    logic [spi_mbe_pkg::KIND_W-1:0]  held_kind_reg,  held_kind_next;
    logic                            clock_reg,      clock_next;
    logic                            data_reg,       data_next;

    logic [TICK_W-1:0]     limit;
    logic [EDGE_XW-1:0]    edge_no;
    logic                  sample;
    logic [FRAME_BITS-1:0] tx_fit;

    assign limit   = TICK_W'((TICK_W'(1) << cfg.div_exp) - TICK_W'(1));
    assign edge_no = {1'b0, edge_count_reg} + EDGE_XW'(1);
    assign sample  = cfg.cpha ? ~edge_no[0] : edge_no[0];
    assign tx_fit  = kind[1] ? '0 : FRAME_BITS'(tx_byte);

    always_comb
    begin
        active_next     = active_reg;
        edge_count_next = edge_count_reg;
        tick_count_next = tick_count_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        held_kind_next  = held_kind_reg;
        clock_next      = clock_reg;
        data_next       = data_reg;
        res             = '0;

        if (active_reg)
        begin
            res.cmd_rejected = cmd_valid;
            if (tick_count_reg >= limit)
            begin
                tick_count_next = '0;
                clock_next      = ~clock_reg;
                if (sample)
                begin
                    shift_in_next = {shift_in_reg[FRAME_BITS-2:0], miso};
                end
                else if (cfg.cpha)
                begin
                    data_next      = shift_out_reg[FRAME_BITS-1];
                    shift_out_next = shift_out_reg << 1;
                end
                else if (edge_no < LAST_EDGE)
                begin
                    shift_out_next = shift_out_reg << 1;
                    data_next      = shift_out_reg[FRAME_BITS-2];
                end
                if (edge_no >= LAST_EDGE)
                begin
                    active_next     = 1'b0;
                    edge_count_next = '0;
                    if (held_kind_reg != spi_mbe_pkg::KIND_SEND)
                    begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = spi_mbe_pkg::RX_W'(shift_in_next);
                    end
                end
                else
                begin
                    edge_count_next = edge_no[EDGE_W-1:0];
                end
            end
            else
            begin
                tick_count_next = tick_count_reg + TICK_W'(1);
            end
        end
        else
        begin
            clock_next = cfg.cpol;
            if (cmd_valid)
            begin
                active_next     = 1'b1;
                held_kind_next  = kind;
                edge_count_next = '0;
                tick_count_next = '0;
                shift_in_next   = '0;
                shift_out_next  = tx_fit;
                if (!cfg.cpha)
                begin
                    data_next = tx_fit[FRAME_BITS-1];
                end
            end
        end

        res.sclk = clock_next;
        res.mosi = data_next;
        res.busy = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            edge_count_reg <= '0;
            tick_count_reg <= '0;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            held_kind_reg  <= '0;
            clock_reg      <= 1'b0;
            data_reg       <= 1'b0;
        end
        else if (step)
        begin
            active_reg     <= active_next;
            edge_count_reg <= edge_count_next;
            tick_count_reg <= tick_count_next;
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            held_kind_reg  <= held_kind_next;
            clock_reg      <= clock_next;
            data_reg       <= data_next;
        end
    end

    // counters rest at zero between frames
    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (edge_count_reg == '0) && (tick_count_reg == '0))
        else $error("counters not cleared while idle");

    a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, edge_count_reg} < LAST_EDGE)
        else $error("edge count beyond frame");

    a_start_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && !active_reg && cmd_valid |=> active_reg)
        else $error("command while idle did not start a frame");

    a_rx_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.rx_valid |=> !active_reg)
        else $error("frame still active after delivery");

endmodule

// ----- rtl/spi_master_byte_engine_unit.sv -----
// ----------------------------------------------------------------------------
// spi_master_byte_engine_unit
// spi master, modes 0 to 3, msb first, one frame per command
// ----------------------------------------------------------------------------
// each input item is one tick of the spi engine: it carries cmd_valid, kind,
// tx_byte and the sampled miso level. every accepted item gives exactly one
// result item with the sclk and mosi levels, busy, an optional received byte
// and the rejected flag for a command that came while a frame was running.
// the result is registered in the output register on acceptance; one
// item is taken per cycle as long as the output side keeps up, since
// in_ready only drops while a held result is not being taken. a stall on
// the output freezes the engine, as no tick is consumed then.
// sclk toggles at tick 2^div_exp - 1; frames end at edge count 2*FRAME_BITS.
// configuration writes go through cfg_valid/cfg_ready (always ready)
// and must be made while no frame is running; the block does not enforce it.
// reset zeroes the engine and config registers, emptying the output register.
// ----------------------------------------------------------------------------
module spi_master_byte_engine_unit #(
    parameter int FRAME_BITS = spi_mbe_pkg::FRAME_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd_valid,
    input  logic [spi_mbe_pkg::KIND_W-1:0]       kind,
    input  logic [spi_mbe_pkg::TX_W-1:0]         tx_byte,
    input  logic                                 miso,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 sclk,
    output logic                                 mosi,
    output logic                                 busy_res,
    output logic                                 rx_valid,
    output logic [spi_mbe_pkg::RX_W-1:0]         rx_byte,
    output logic                                 cmd_rejected,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spi_mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spi_mbe_pkg::CFG_DATA_W-1:0]   cfg_data
);

    spi_mbe_pkg::cfg_t cfg_reg, cfg_next;
    spi_mbe_pkg::res_t res_reg, res;
    logic              out_valid_reg, out_valid_next;
    logic              step;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                spi_mbe_pkg::CFG_IDX_DIV:  cfg_next.div_exp = cfg_data[spi_mbe_pkg::DIV_W-1:0];
                spi_mbe_pkg::CFG_IDX_CPOL: cfg_next.cpol    = cfg_data[0];
                spi_mbe_pkg::CFG_IDX_CPHA: cfg_next.cpha    = cfg_data[0];
                default:                   cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spi_mbe_shifter #(
        .FRAME_BITS (FRAME_BITS)
    ) u_shifter (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .cmd_valid (cmd_valid),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .miso      (miso),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // result item register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sclk         = res_reg.sclk;
    assign mosi         = res_reg.mosi;
    assign busy_res     = res_reg.busy;
    assign rx_valid     = res_reg.rx_valid;
    assign rx_byte      = res_reg.rx_byte;
    assign cmd_rejected = res_reg.cmd_rejected;

endmodule
